@@ rtl/pctd_pkg.sv @@
// shared types and codes for the prefix code tree decoder
`timescale 1ns / 1ps
`default_nettype none

package pctd_pkg;

  localparam int KIND_W = 2;
  localparam int SYM_W = 8;
  localparam int CODE_W = 16;
  localparam int CODE_IDX_W = 4;
  localparam int LEN_W = 5;
  localparam int STATUS_W = 2;

  // transaction kinds
  localparam logic [KIND_W-1:0] KIND_DEFINE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DECODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SYMBOL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0] symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0] code_length;
    logic bit_req;
  } item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SYM_W-1:0] symbol_res;
  } result_t;

  // write enables of the node store
  typedef struct packed {
    logic left;
    logic right;
    logic sym;
  } store_we_t;

endpackage

`default_nettype wire

@@ rtl/pctd_node_store.sv @@
// node table: left child, right child and symbol memories, registered read
`timescale 1ns / 1ps
`default_nettype none

module pctd_node_store #(
  parameter int NODE_COUNT = 256
) (
  input wire logic clk,
  input wire logic [$clog2(NODE_COUNT)-1:0] rd_addr,
  input wire logic [$clog2(NODE_COUNT)-1:0] wr_addr,
  input wire pctd_pkg::store_we_t we,
  input wire logic [$clog2(NODE_COUNT)-1:0] wr_left,
  input wire logic [$clog2(NODE_COUNT)-1:0] wr_right,
  input wire logic [pctd_pkg::SYM_W-1:0] wr_sym,
  output logic [$clog2(NODE_COUNT)-1:0] rd_left,
  output logic [$clog2(NODE_COUNT)-1:0] rd_right,
  output logic [pctd_pkg::SYM_W-1:0] rd_sym
);

  localparam int NODE_W = $clog2(NODE_COUNT);

  logic [NODE_W-1:0] left_mem [NODE_COUNT];
  logic [NODE_W-1:0] right_mem [NODE_COUNT];
  logic [pctd_pkg::SYM_W-1:0] sym_mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (we.left) begin
      left_mem[wr_addr] <= wr_left;
    end
    if (we.right) begin
      right_mem[wr_addr] <= wr_right;
    end
    if (we.sym) begin
      sym_mem[wr_addr] <= wr_sym;
    end
    rd_left <= left_mem[rd_addr];
    rd_right <= right_mem[rd_addr];
    rd_sym <= sym_mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/prefix_code_tree_decoder.sv @@
// top level of the prefix code tree decoder
`timescale 1ns / 1ps
`default_nettype none

// Binary prefix-code tree decoder. A transaction is taken when start is high and
// busy is low; exactly one result per transaction appears on result for a single
// cycle with done high, and the receiver must take it then (there is no stall).
// The tree lives in a node memory with a registered read; the children
// of the root node are kept in flip-flops, so reset and clear take effect at once
// with no sweep. Clear, unused kinds and a decode bit that hits a missing branch
// answer straight from idle; any other decode bit goes on to the decode state for
// the node memory read of the child reached (the children of the current node are
// held in registers). A define walks its code bits: a bit that follows an existing
// branch takes a read and a step, and a bit that allocates a node takes a read, a
// link and a step that zeroes the new node. A define that finds no node left stops
// there with status table full, in the cycle after a define that had ended at that
// node would have answered. A new transaction can be taken in the cycle that
// carries the previous result.
module prefix_code_tree_decoder #(
  parameter int NODE_COUNT = 256,
  parameter int MAX_CODE_LENGTH = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  output logic busy,
  input wire pctd_pkg::item_t cmd,
  output logic done,
  output pctd_pkg::result_t result
);

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int FREE_W = NODE_W + 1;
  localparam int LEN_W = pctd_pkg::LEN_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_READ,
    S_STEP,
    S_INIT
  } state_t;

  state_t state;

  // define walk context
  logic [NODE_W-1:0] p;
  logic [LEN_W-1:0] j;
  logic [pctd_pkg::SYM_W-1:0] sym_q;
  logic [pctd_pkg::CODE_W-1:0] bits_q;

  // decode context: current node and a copy of its children
  logic [NODE_W-1:0] cur;
  logic [NODE_W-1:0] cur_left;
  logic [NODE_W-1:0] cur_right;
  logic [NODE_W-1:0] nxt_q;

  // root children live in flip-flops
  logic [NODE_W-1:0] root_left;
  logic [NODE_W-1:0] root_right;

  logic [FREE_W-1:0] next_free;

  // node store ports
  logic [NODE_W-1:0] rd_addr;
  logic [NODE_W-1:0] rd_left;
  logic [NODE_W-1:0] rd_right;
  logic [pctd_pkg::SYM_W-1:0] rd_sym;
  pctd_pkg::store_we_t we;
  logic [NODE_W-1:0] wr_child;

  // combinational helpers
  logic [NODE_W-1:0] dec_nxt;
  logic [NODE_W-1:0] p_left;
  logic [NODE_W-1:0] p_right;
  logic [LEN_W-1:0] pos;
  logic step_bit;
  logic [NODE_W-1:0] slot;
  logic full;
  logic [NODE_W-1:0] new_node;
  logic [LEN_W-1:0] len_sat;

  assign busy = (state != S_IDLE);

  // child of the current node for the incoming decode bit
  always_comb begin
    if (cur == '0) begin
      dec_nxt = cmd.bit_req ? root_right : root_left;
    end else begin
      dec_nxt = cmd.bit_req ? cur_right : cur_left;
    end
  end

  // children of the walk node: root from flip-flops, others from memory
  assign p_left = (p == '0) ? root_left : rd_left;
  assign p_right = (p == '0) ? root_right : rd_right;

  // code bit for this step, bits above the code field read as zero
  assign pos = j - LEN_W'(1);
  assign step_bit = (pos < LEN_W'(pctd_pkg::CODE_W)) ?
                    bits_q[pos[pctd_pkg::CODE_IDX_W-1:0]] : 1'b0;
  assign slot = step_bit ? p_right : p_left;

  assign full = (next_free >= FREE_W'(NODE_COUNT));
  assign new_node = next_free[NODE_W-1:0];

  assign len_sat = (int'(cmd.code_length) > MAX_CODE_LENGTH) ?
                   LEN_W'(MAX_CODE_LENGTH) : cmd.code_length;

  // memory read address: decode child when idle, walk node otherwise
  assign rd_addr = (state == S_IDLE) ? dec_nxt : p;

  // memory writes: link in a new child, zero a fresh node, store a symbol
  always_comb begin
    we = '0;
    wr_child = new_node;
    case (state)
      S_READ: begin
        we.sym = (j == '0) && (p != '0);
      end
      S_STEP: begin
        if ((slot == '0) && !full && (p != '0)) begin
          we.left = !step_bit;
          we.right = step_bit;
        end
      end
      S_INIT: begin
        we = '1;
        wr_child = '0;
      end
      default: begin
        we = '0;
      end
    endcase
  end

  pctd_node_store #(
    .NODE_COUNT(NODE_COUNT)
  ) u_store (
    .clk(clk),
    .rd_addr(rd_addr),
    .wr_addr(p),
    .we(we),
    .wr_left(wr_child),
    .wr_right(wr_child),
    .wr_sym((state == S_INIT) ? '0 : sym_q),
    .rd_left(rd_left),
    .rd_right(rd_right),
    .rd_sym(rd_sym)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      next_free <= FREE_W'(1);
      cur <= '0;
      root_left <= '0;
      root_right <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            case (cmd.kind)
              pctd_pkg::KIND_DEFINE: begin
                p <= '0;
                j <= len_sat;
                sym_q <= cmd.symbol;
                bits_q <= cmd.code_bits;
                state <= S_READ;
              end
              pctd_pkg::KIND_DECODE: begin
                if (dec_nxt == '0) begin
                  // missing branch, back to the root
                  done <= 1'b1;
                  result <= '{status: pctd_pkg::ST_MISSING, symbol_res: '0};
                  cur <= '0;
                end else begin
                  nxt_q <= dec_nxt;
                  state <= S_DEC;
                end
              end
              pctd_pkg::KIND_CLEAR: begin
                root_left <= '0;
                root_right <= '0;
                next_free <= FREE_W'(1);
                cur <= '0;
                done <= 1'b1;
                result <= '{status: pctd_pkg::ST_OK, symbol_res: '0};
              end
              default: begin
                done <= 1'b1;
                result <= '{status: pctd_pkg::ST_OK, symbol_res: '0};
              end
            endcase
          end
        end
        S_DEC: begin
          done <= 1'b1;
          state <= S_IDLE;
          if (rd_left == '0) begin
            // no left child: leaf, emit and restart at the root
            result <= '{status: pctd_pkg::ST_SYMBOL, symbol_res: rd_sym};
            cur <= '0;
          end else begin
            result <= '{status: pctd_pkg::ST_OK, symbol_res: '0};
            cur <= nxt_q;
            cur_left <= rd_left;
            cur_right <= rd_right;
          end
        end
        S_READ: begin
          if (j == '0) begin
            // end of code, symbol goes into the walk node; the root is
            // never reached as a decode target, so its symbol is not kept
            done <= 1'b1;
            result <= '{status: pctd_pkg::ST_OK, symbol_res: '0};
            state <= S_IDLE;
          end else begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (slot != '0) begin
            p <= slot;
            j <= j - LEN_W'(1);
            state <= S_READ;
          end else if (full) begin
            done <= 1'b1;
            result <= '{status: pctd_pkg::ST_FULL, symbol_res: '0};
            state <= S_IDLE;
          end else begin
            // link the new node; keep the decode copy coherent
            if (p == '0) begin
              if (step_bit) begin
                root_right <= new_node;
              end else begin
                root_left <= new_node;
              end
            end else if (p == cur) begin
              if (step_bit) begin
                cur_right <= new_node;
              end else begin
                cur_left <= new_node;
              end
            end
            p <= new_node;
            j <= j - LEN_W'(1);
            next_free <= next_free + FREE_W'(1);
            state <= S_INIT;
          end
        end
        S_INIT: begin
          state <= S_READ;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // allocation never runs past the table
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= FREE_W'(NODE_COUNT))
    else $error("next free node beyond table");

  // the decode position is always the root or an allocated node
  a_cur_alloc: assert property (@(posedge clk) disable iff (rst)
    (cur == '0) || (FREE_W'(cur) < next_free))
    else $error("current node not allocated");

  // a clear transaction answers in the next cycle with status ok
  a_clear_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.kind == pctd_pkg::KIND_CLEAR)) |=>
      (done && (result.status == pctd_pkg::ST_OK) && (next_free == FREE_W'(1))))
    else $error("clear did not complete");

  // a symbol only accompanies the symbol status
  a_sym_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status != pctd_pkg::ST_SYMBOL)) |-> (result.symbol_res == '0))
    else $error("symbol on a non-symbol result");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// self-checking testbench for the prefix code tree decoder
`timescale 1ns / 1ps

module tb_top;

  // block geometry, as instantiated
  localparam int NODES = 256;
  localparam int MAX_LEN = 16;

  // kind code the block leaves unused
  localparam logic [pctd_pkg::KIND_W-1:0] KIND_SPARE = 2'd3;

  // items per idling phase of the random part
  localparam int PHASE_ITEMS = 290;

  // drain time: the longest transaction, a define that allocates a node for every code bit, plus margin
  localparam int DRAIN_CYCLES = 2 + 3 * MAX_LEN + 10;

  typedef struct {
    logic [pctd_pkg::CODE_W-1:0] bits;
    int                          len;
  } codeword_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  pctd_pkg::item_t   cmd = '0;
  logic              busy;
  logic              done;
  pctd_pkg::result_t result;

  // stimulus waiting for the driver, and results still owed by the block
  pctd_pkg::item_t   pending_items[$];
  pctd_pkg::result_t expected_results[$];
  codeword_t         code_book[$];

  int idle_pct = 0;
  int n_queued = 0;
  int n_accepted = 0;
  int n_symbols = 0;
  int n_missing = 0;
  int n_full = 0;
  int errors = 0;

  // shadow copy of the code tree, root at node 0, child 0 means no child
  logic [7:0]                 tree_left[NODES];
  logic [7:0]                 tree_right[NODES];
  logic [pctd_pkg::SYM_W-1:0] node_sym[NODES];
  logic [8:0]                 free_node;
  logic [7:0]                 walk_node;

  prefix_code_tree_decoder #(
    .NODE_COUNT(NODES),
    .MAX_CODE_LENGTH(MAX_LEN)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // tree predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_tree();
    for (int i = 0; i < NODES; i++) begin
      tree_left[i] = '0;
      tree_right[i] = '0;
      node_sym[i] = '0;
    end
    free_node = 9'd1;
    walk_node = '0;
  endfunction

  // walk the code from the root, msb first, growing missing branches
  function automatic logic [pctd_pkg::STATUS_W-1:0] insert_code(
      logic [pctd_pkg::SYM_W-1:0] sym,
      logic [pctd_pkg::CODE_W-1:0] bits,
      logic [pctd_pkg::LEN_W-1:0] len);
    int n_bits;
    int node;
    int child;
    n_bits = (len > MAX_LEN) ? MAX_LEN : int'(len);
    node = 0;
    for (int pos = n_bits - 1; pos >= 0; pos--) begin
      child = bits[pos] ? tree_right[node] : tree_left[node];
      if (child == 0) begin
        // no node left: branches grown so far stay, symbol is dropped
        if (free_node >= NODES) return pctd_pkg::ST_FULL;
        child = free_node;
        free_node = free_node + 9'd1;
        tree_left[child] = '0;
        tree_right[child] = '0;
        node_sym[child] = '0;
        if (bits[pos]) tree_right[node] = child[7:0];
        else tree_left[node] = child[7:0];
      end
      node = child;
    end
    node_sym[node] = sym;
    return pctd_pkg::ST_OK;
  endfunction

  // expected result of one transaction, updating the shadow tree
  function automatic pctd_pkg::result_t tree_step(pctd_pkg::item_t it);
    pctd_pkg::result_t res;
    logic [7:0]        nxt;
    res = '0;
    case (it.kind)
      pctd_pkg::KIND_DEFINE: begin
        res.status = insert_code(it.symbol, it.code_bits, it.code_length);
      end
      pctd_pkg::KIND_DECODE: begin
        nxt = it.bit_req ? tree_right[walk_node] : tree_left[walk_node];
        if (nxt == 0) begin
          res.status = pctd_pkg::ST_MISSING;
          walk_node = '0;
        end else if (tree_left[nxt] == 0) begin
          // no left child: this is a leaf
          res.status = pctd_pkg::ST_SYMBOL;
          res.symbol_res = node_sym[nxt];
          walk_node = '0;
        end else begin
          walk_node = nxt;
        end
      end
      pctd_pkg::KIND_CLEAR: begin
        tree_left[0] = '0;
        tree_right[0] = '0;
        node_sym[0] = '0;
        free_node = 9'd1;
        walk_node = '0;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: presents queued items, predicts each one as it is taken
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(tree_step(cmd));
        n_accepted++;
      end
      // a new item may go out once the current one is taken or none is up
      if (!start || !busy) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= idle_pct) begin
          cmd <= pending_items.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobed result against the oldest expectation
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    pctd_pkg::result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, got status %0d symbol %02h",
                 $time, result.status, result.symbol_res);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, result.status);
          errors++;
        end
        if (result.symbol_res !== want.symbol_res) begin
          $display("%0t: symbol mismatch, expected %02h, got %02h",
                   $time, want.symbol_res, result.symbol_res);
          errors++;
        end
        case (want.status)
          pctd_pkg::ST_SYMBOL:  n_symbols++;
          pctd_pkg::ST_MISSING: n_missing++;
          pctd_pkg::ST_FULL:    n_full++;
          default: begin
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // item builders: fields a kind does not use carry random noise
  // ---------------------------------------------------------------------------

  function automatic pctd_pkg::item_t random_item();
    pctd_pkg::item_t it;
    it.kind = pctd_pkg::KIND_W'($urandom_range(3));
    it.symbol = pctd_pkg::SYM_W'($urandom_range(255));
    it.code_bits = pctd_pkg::CODE_W'($urandom_range(16'hFFFF));
    it.code_length = pctd_pkg::LEN_W'($urandom_range(31));
    it.bit_req = 1'($urandom_range(1));
    return it;
  endfunction

  function automatic pctd_pkg::item_t define_item(logic [pctd_pkg::SYM_W-1:0] sym,
                                                  logic [pctd_pkg::CODE_W-1:0] bits,
                                                  logic [pctd_pkg::LEN_W-1:0] len);
    pctd_pkg::item_t it;
    it = random_item();
    it.kind = pctd_pkg::KIND_DEFINE;
    it.symbol = sym;
    it.code_bits = bits;
    it.code_length = len;
    return it;
  endfunction

  function automatic pctd_pkg::item_t decode_item(logic b);
    pctd_pkg::item_t it;
    it = random_item();
    it.kind = pctd_pkg::KIND_DECODE;
    it.bit_req = b;
    return it;
  endfunction

  function automatic pctd_pkg::item_t clear_item();
    pctd_pkg::item_t it;
    it = random_item();
    it.kind = pctd_pkg::KIND_CLEAR;
    return it;
  endfunction

  task automatic queue_item(pctd_pkg::item_t it);
    pending_items.push_back(it);
    n_queued++;
  endtask

  // ---------------------------------------------------------------------------
  // random sessions
  // ---------------------------------------------------------------------------

  // build a small code book, then decode whole codewords with a little noise
  task automatic codebook_session();
    int                          n_codes;
    int                          n_words;
    int                          len;
    int                          pick;
    logic [pctd_pkg::CODE_W-1:0] bits;
    code_book.delete();
    if ($urandom_range(99) < 80) queue_item(clear_item());
    n_codes = $urandom_range(2, 12);
    for (int k = 0; k < n_codes; k++) begin
      case ($urandom_range(19))
        0:       len = 0;
        1:       len = $urandom_range(17, 31);
        2, 3:    len = $urandom_range(9, 16);
        default: len = $urandom_range(1, 8);
      endcase
      bits = pctd_pkg::CODE_W'($urandom_range(16'hFFFF));
      queue_item(define_item(pctd_pkg::SYM_W'($urandom_range(255)), bits,
                             pctd_pkg::LEN_W'(len)));
      if (len > 0) code_book.push_back('{bits, (len > MAX_LEN) ? MAX_LEN : len});
    end
    if (code_book.size() == 0) return;
    n_words = $urandom_range(4, 16);
    for (int w = 0; w < n_words; w++) begin
      if ($urandom_range(9) == 0) queue_item(random_item());
      pick = $urandom_range(code_book.size() - 1);
      for (int pos = code_book[pick].len - 1; pos >= 0; pos--)
        queue_item(decode_item(code_book[pick].bits[pos]));
    end
  endtask

  // long codes until the node table runs out
  task automatic fill_session();
    int n_codes;
    if ($urandom_range(1)) queue_item(clear_item());
    n_codes = $urandom_range(12, 24);
    for (int k = 0; k < n_codes; k++)
      queue_item(define_item(pctd_pkg::SYM_W'($urandom_range(255)),
                             pctd_pkg::CODE_W'($urandom_range(16'hFFFF)),
                             pctd_pkg::LEN_W'($urandom_range(0, 3) == 0 ?
                                              $urandom_range(17, 31) : MAX_LEN)));
    for (int k = 0; k < 12; k++) queue_item(decode_item(1'($urandom_range(1))));
  endtask

  task automatic noise_session();
    int n_items;
    n_items = $urandom_range(5, 20);
    for (int k = 0; k < n_items; k++) queue_item(random_item());
  endtask

  // every queued item taken and every expected result seen
  task automatic wait_idle();
    @(posedge clk);
    while (pending_items.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  initial begin
    int              phase_idle[4];
    int              phase_start;
    int              roll;
    pctd_pkg::item_t it;
    // sender idle percentage per phase; the receiver cannot stall, so its
    // phase runs with a busy sender
    phase_idle = '{0, 83, 0, 37};
    clear_tree();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: empty tree, both branches missing
    queue_item(decode_item(1'b0));
    queue_item(decode_item(1'b1));
    // empty code ends at the root, whose symbol the block does not keep
    queue_item(define_item(8'hA5, 16'h1234, 5'd0));
    // unused kind with every field high
    it = '1;
    it.kind = KIND_SPARE;
    queue_item(it);
    // codes 0, 10 and 11 with extreme symbols, noise above the code
    queue_item(define_item(8'h00, 16'hFFFE, 5'd1));
    queue_item(define_item(8'hFF, 16'hFFF2, 5'd2));
    queue_item(define_item(8'h3C, 16'h0003, 5'd2));
    queue_item(decode_item(1'b0));
    queue_item(decode_item(1'b1));
    queue_item(decode_item(1'b1));
    // overlong code saturates to the longest length
    queue_item(define_item(8'h81, 16'hFFFF, 5'd31));
    queue_item(clear_item());
    // long codes branching near the root run the table out of nodes
    for (int i = 0; i < 19; i++)
      queue_item(define_item(pctd_pkg::SYM_W'(i),
                             {4'(i), (i >= 16) ? 12'h800 : 12'h000},
                             pctd_pkg::LEN_W'(MAX_LEN)));
    wait_idle();

    // random part, one idling phase at a time
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      phase_start = n_queued;
      while (n_queued - phase_start < PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 70) codebook_session();
        else if (roll < 85) fill_session();
        else noise_session();
      end
      wait_idle();
    end

    // let any stray result show up
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end
    $display("ran %0d transactions over four idling phases", n_accepted);
    $display("saw %0d decoded symbols, %0d missing branches, %0d table full",
             n_symbols, n_missing, n_full);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("%0t: timeout with %0d items queued and %0d results owed",
             $time, pending_items.size(), expected_results.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
